@@ hw/rtl/plmm_pkg.sv @@
// ----------------------------------------------------------------------------
// plmm_pkg: shared types for the positional list with min/max
// Operation, status and cell command codes, the scan word that moves
// along the cell row, and the sequencer state type.
// ----------------------------------------------------------------------------
package plmm_pkg;

  // Widths fixed by the word format.
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 8;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_QUERY  = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What every cell does with its entry in a cycle.
  typedef enum logic [1:0] {
    C_HOLD,
    C_INS,
    C_DEL
  } cell_op_t;

  // Command broadcast to the cell row.
  typedef struct packed {
    cell_op_t           op;
    logic [VAL_W-1:0]   value;
  } cell_cmd_t;

  // Value part of the scan word passed from cell to cell.
  typedef struct packed {
    logic               have;
    logic [VAL_W-1:0]   max_v;
    logic [VAL_W-1:0]   min_v;
    logic [VAL_W-1:0]   rd_v;
  } scan_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage

@@ hw/rtl/positional_list_with_min_max.sv @@
// ----------------------------------------------------------------------------
// positional_list_with_min_max: ordered list with insert, delete, read and
// max/min query
// Keeps up to DEPTH signed 32-bit entries in a row of cells; insert and
// delete shift the whole row at once, query and read sweep a scan word
// through the row.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Word
// input     in         start && !busy      in_func, in_position, in_value_in
// result    out        out_valid (1 cycle) out_status, out_count_out,
//                                          out_first_value/position,
//                                          out_second_value/position
//
// Insert, delete and every error word: result strobe in the cycle after the
// accept, busy stays low, so one such word can be taken each cycle.
// Successful query and read: busy stays high while the scan word crosses
// the row of DEPTH cells, one cell per cycle, and the result strobe is
// registered from the end of the sweep.
// Synchronous reset empties the list at once; there is no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_list_with_min_max #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic [plmm_pkg::POS_W-1:0]        in_position,
  input  logic signed [plmm_pkg::VAL_W-1:0] in_value_in,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [plmm_pkg::POS_W-1:0]        out_count_out,
  output logic signed [plmm_pkg::VAL_W-1:0] out_first_value,
  output logic [plmm_pkg::POS_W-1:0]        out_first_position,
  output logic signed [plmm_pkg::VAL_W-1:0] out_second_value,
  output logic [plmm_pkg::POS_W-1:0]        out_second_position
);

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned PW  = ((CW > plmm_pkg::POS_W) ? CW : plmm_pkg::POS_W) + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  plmm_pkg::state_t     state_r;
  plmm_pkg::state_t     state_nxt;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [CW-1:0]        scan_cnt_r;
  logic [CW-1:0]        scan_cnt_nxt;
  logic                 is_query_r;
  logic [IW-1:0]        rd_idx_r;

  logic                 accept;
  logic                 scan_start;
  logic                 scan_done;
  logic [PW-1:0]        pos_ext;
  logic [PW-1:0]        cnt_ext;
  logic [PW-1:0]        cnt_nxt_ext;
  logic [PW-1:0]        pos_m1;
  logic [IW-1:0]        pos_idx;
  plmm_pkg::status_t    status_c;
  plmm_pkg::cell_cmd_t  cmd;

  plmm_pkg::scan_t      scan_res;
  logic [IW-1:0]        max_idx_res;
  logic [IW-1:0]        min_idx_res;
  logic [PW-1:0]        max_pos;
  logic [PW-1:0]        min_pos;

  logic                              out_valid_r;
  logic [1:0]                        out_status_r;
  logic [plmm_pkg::POS_W-1:0]        out_count_r;
  logic [plmm_pkg::VAL_W-1:0]        out_first_value_r;
  logic [plmm_pkg::POS_W-1:0]        out_first_pos_r;
  logic [plmm_pkg::VAL_W-1:0]        out_second_value_r;
  logic [plmm_pkg::POS_W-1:0]        out_second_pos_r;

  assign accept = start && !busy;

  // Position checks in a common width with room for count plus one.
  always_comb begin
    pos_ext = PW'(in_position);
    cnt_ext = PW'(count_r);
    pos_m1  = pos_ext - PW'(1);
    pos_idx = pos_m1[IW-1:0];
    if (in_func == plmm_pkg::FN_INSERT) begin
      if (count_r == FULL_CNT) begin
        status_c = plmm_pkg::ST_FULL;
      end else if ((pos_ext == '0) || (pos_ext > (cnt_ext + PW'(1)))) begin
        status_c = plmm_pkg::ST_RANGE;
      end else begin
        status_c = plmm_pkg::ST_OK;
      end
    end else if (count_r == '0) begin
      status_c = plmm_pkg::ST_EMPTY;
    end else if (in_func == plmm_pkg::FN_QUERY) begin
      status_c = plmm_pkg::ST_OK;
    end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
      status_c = plmm_pkg::ST_RANGE;
    end else begin
      status_c = plmm_pkg::ST_OK;
    end
  end

  // Command to the cell row and the new count.
  always_comb begin
    cmd.op    = plmm_pkg::C_HOLD;
    cmd.value = in_value_in;
    count_nxt = count_r;
    if (accept && (status_c == plmm_pkg::ST_OK)) begin
      if (in_func == plmm_pkg::FN_INSERT) begin
        cmd.op    = plmm_pkg::C_INS;
        count_nxt = count_r + CW'(1);
      end else if (in_func == plmm_pkg::FN_DELETE) begin
        cmd.op    = plmm_pkg::C_DEL;
        count_nxt = count_r - CW'(1);
      end
    end
  end

  assign cnt_nxt_ext = PW'(count_nxt);

  assign scan_start = accept && (status_c == plmm_pkg::ST_OK) &&
                      ((in_func == plmm_pkg::FN_QUERY) || (in_func == plmm_pkg::FN_READ));
  assign scan_done  = (state_r == plmm_pkg::S_SCAN) && (scan_cnt_r == FULL_CNT);

  // Sequencer next state.
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    case (state_r)
      plmm_pkg::S_IDLE: begin
        scan_cnt_nxt = '0;
        if (scan_start) begin
          state_nxt = plmm_pkg::S_SCAN;
        end
      end
      plmm_pkg::S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        if (scan_done) begin
          state_nxt = plmm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plmm_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    case (state_r)
      plmm_pkg::S_SCAN: busy = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plmm_pkg::S_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= (accept && !scan_start) || scan_done;
    end
  end

  // Operation held for the sweep.
  always_ff @(posedge clk) begin
    if (scan_start) begin
      is_query_r <= (in_func == plmm_pkg::FN_QUERY);
      rd_idx_r   <= pos_idx;
    end
  end

  plmm_chain #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_chain (
    .clk         (clk),
    .cmd         (cmd),
    .cmd_idx     (pos_idx),
    .count       (count_r),
    .rd_idx      (rd_idx_r),
    .scan_res    (scan_res),
    .max_idx_res (max_idx_res),
    .min_idx_res (min_idx_res)
  );

  assign max_pos = PW'(max_idx_res) + PW'(1);
  assign min_pos = PW'(min_idx_res) + PW'(1);

  // Result word: immediate for shifts and errors, from the row end for sweeps.
  always_ff @(posedge clk) begin
    if (scan_done) begin
      out_status_r <= plmm_pkg::ST_OK;
      out_count_r  <= cnt_ext[plmm_pkg::POS_W-1:0];
      if (is_query_r) begin
        out_first_value_r  <= scan_res.max_v;
        out_first_pos_r    <= max_pos[plmm_pkg::POS_W-1:0];
        out_second_value_r <= scan_res.min_v;
        out_second_pos_r   <= min_pos[plmm_pkg::POS_W-1:0];
      end else begin
        out_first_value_r  <= scan_res.rd_v;
        out_first_pos_r    <= '0;
        out_second_value_r <= '0;
        out_second_pos_r   <= '0;
      end
    end else if (accept) begin
      out_status_r       <= status_c;
      out_count_r        <= cnt_nxt_ext[plmm_pkg::POS_W-1:0];
      out_first_value_r  <= '0;
      out_first_pos_r    <= '0;
      out_second_value_r <= '0;
      out_second_pos_r   <= '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_count_out       = out_count_r;
  assign out_first_value     = out_first_value_r;
  assign out_first_position  = out_first_pos_r;
  assign out_second_value    = out_second_value_r;
  assign out_second_position = out_second_pos_r;

endmodule

@@ hw/rtl/plmm_cell.sv @@
// ----------------------------------------------------------------------------
// plmm_cell: one list cell
// Holds one entry, shifts it to or from its neighbors on insert and delete,
// and folds its entry into the scan word moving along the row.
// ----------------------------------------------------------------------------
module plmm_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 7,
  parameter int unsigned CW  = 8
) (
  input  logic                        clk,
  input  plmm_pkg::cell_cmd_t         cmd,
  input  logic [IW-1:0]               cmd_idx,
  input  logic [CW-1:0]               count,
  input  logic [IW-1:0]               rd_idx,
  input  logic [plmm_pkg::VAL_W-1:0]  left_entry,
  input  logic [plmm_pkg::VAL_W-1:0]  right_entry,
  output logic [plmm_pkg::VAL_W-1:0]  entry,
  input  plmm_pkg::scan_t             scan_in,
  input  logic [IW-1:0]               max_idx_in,
  input  logic [IW-1:0]               min_idx_in,
  output plmm_pkg::scan_t             scan_out,
  output logic [IW-1:0]               max_idx_out,
  output logic [IW-1:0]               min_idx_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  logic [plmm_pkg::VAL_W-1:0] entry_r;
  logic [plmm_pkg::VAL_W-1:0] entry_nxt;
  plmm_pkg::scan_t            scan_r;
  plmm_pkg::scan_t            scan_nxt;
  logic [IW-1:0]              max_idx_r;
  logic [IW-1:0]              max_idx_nxt;
  logic [IW-1:0]              min_idx_r;
  logic [IW-1:0]              min_idx_nxt;
  logic                       active;

  // Entry update: insert takes the new value or the left neighbor's entry,
  // delete takes the right neighbor's entry.
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      plmm_pkg::C_INS: begin
        if (MY_IDX == cmd_idx) begin
          entry_nxt = cmd.value;
        end else if (MY_IDX > cmd_idx) begin
          entry_nxt = left_entry;
        end
      end
      plmm_pkg::C_DEL: begin
        if (MY_IDX >= cmd_idx) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // Scan step: strict compares keep the first occurrence on ties.
  always_comb begin
    active      = (MY_CNT < count);
    scan_nxt    = scan_in;
    max_idx_nxt = max_idx_in;
    min_idx_nxt = min_idx_in;
    if (active) begin
      scan_nxt.have = 1'b1;
      if (!scan_in.have || ($signed(entry_r) > $signed(scan_in.max_v))) begin
        scan_nxt.max_v = entry_r;
        max_idx_nxt    = MY_IDX;
      end
      if (!scan_in.have || ($signed(entry_r) < $signed(scan_in.min_v))) begin
        scan_nxt.min_v = entry_r;
        min_idx_nxt    = MY_IDX;
      end
    end
    if (MY_IDX == rd_idx) begin
      scan_nxt.rd_v = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r   <= entry_nxt;
    scan_r    <= scan_nxt;
    max_idx_r <= max_idx_nxt;
    min_idx_r <= min_idx_nxt;
  end

  assign entry       = entry_r;
  assign scan_out    = scan_r;
  assign max_idx_out = max_idx_r;
  assign min_idx_out = min_idx_r;

endmodule

@@ hw/rtl/plmm_chain.sv @@
// ----------------------------------------------------------------------------
// plmm_chain: row of list cells
// Links each cell to its neighbors for shifting and threads the scan word
// from the first cell to the last.
// ----------------------------------------------------------------------------
module plmm_chain #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned IW    = 7,
  parameter int unsigned CW    = 8
) (
  input  logic                 clk,
  input  plmm_pkg::cell_cmd_t  cmd,
  input  logic [IW-1:0]        cmd_idx,
  input  logic [CW-1:0]        count,
  input  logic [IW-1:0]        rd_idx,
  output plmm_pkg::scan_t      scan_res,
  output logic [IW-1:0]        max_idx_res,
  output logic [IW-1:0]        min_idx_res
);

  logic [plmm_pkg::VAL_W-1:0] entry_w [DEPTH];
  plmm_pkg::scan_t            scan_w  [DEPTH+1];
  logic [IW-1:0]              max_w   [DEPTH+1];
  logic [IW-1:0]              min_w   [DEPTH+1];

  // The scan word enters the first cell empty.
  assign scan_w[0] = '0;
  assign max_w[0]  = '0;
  assign min_w[0]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [plmm_pkg::VAL_W-1:0] left_e;
    logic [plmm_pkg::VAL_W-1:0] right_e;

    // Edge cells see zero beyond the row; that value is never counted.
    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_left
      assign left_e = entry_w[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign right_e = '0;
    end else begin : g_right
      assign right_e = entry_w[i+1];
    end

    plmm_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cmd_idx     (cmd_idx),
      .count       (count),
      .rd_idx      (rd_idx),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (entry_w[i]),
      .scan_in     (scan_w[i]),
      .max_idx_in  (max_w[i]),
      .min_idx_in  (min_w[i]),
      .scan_out    (scan_w[i+1]),
      .max_idx_out (max_w[i+1]),
      .min_idx_out (min_w[i+1])
    );
  end

  assign scan_res    = scan_w[DEPTH];
  assign max_idx_res = max_w[DEPTH];
  assign min_idx_res = min_w[DEPTH];

endmodule

@@ hw/rtl/plmm_checker.sv @@
// ----------------------------------------------------------------------------
// plmm_checker: port-level checks for the positional list
// Watches the top level's ports and flags results that break the list's
// timing or status rules.
// ----------------------------------------------------------------------------
module plmm_checker #(
  parameter int unsigned DEPTH = 128
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        in_func,
  input logic [plmm_pkg::POS_W-1:0]        in_position,
  input logic signed [plmm_pkg::VAL_W-1:0] in_value_in,
  input logic                              out_valid,
  input logic [1:0]                        out_status,
  input logic [plmm_pkg::POS_W-1:0]        out_count_out,
  input logic signed [plmm_pkg::VAL_W-1:0] out_first_value,
  input logic [plmm_pkg::POS_W-1:0]        out_first_position,
  input logic signed [plmm_pkg::VAL_W-1:0] out_second_value,
  input logic [plmm_pkg::POS_W-1:0]        out_second_position
);

  // Shift operations answer in the next cycle.
  a_shift_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_func == plmm_pkg::FN_INSERT) ||
                        (in_func == plmm_pkg::FN_DELETE))) |=> out_valid)
    else $error("insert or delete gave no result in the next cycle");

  // The end of a sweep always brings its result.
  a_sweep_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("sweep ended without a result");

  // A failed operation reports zeros in every value and position field.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != plmm_pkg::ST_OK)) |->
      ((out_first_value == '0) && (out_first_position == '0) &&
       (out_second_value == '0) && (out_second_position == '0)))
    else $error("error result carries nonzero data");

  // An empty-list status only comes with a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == plmm_pkg::ST_EMPTY)) |-> (out_count_out == '0))
    else $error("empty status with a nonzero count");

  // The count never exceeds the list depth.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_count_out) <= int'(DEPTH)))
    else $error("count above the list depth");

endmodule

bind positional_list_with_min_max plmm_checker #(.DEPTH(DEPTH)) u_plmm_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for positional_list_with_min_max
// Drives insert, delete, query and read words through the start/busy port,
// predicts every result from a local copy of the list, and compares each
// strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DEPTH    = 128;
  localparam int          WD_LIMIT = 5000;
  localparam int unsigned POS_W    = plmm_pkg::POS_W;
  localparam int unsigned VAL_W    = plmm_pkg::VAL_W;

  // One result word as the block reports it.
  typedef struct packed {
    plmm_pkg::status_t        status;
    logic [POS_W-1:0]         cnt_out;
    logic signed [VAL_W-1:0]  max_val;
    logic [POS_W-1:0]         max_pos;
    logic signed [VAL_W-1:0]  min_val;
    logic [POS_W-1:0]         min_pos;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                in_func = plmm_pkg::FN_INSERT;
  logic [POS_W-1:0]          in_position = '0;
  logic signed [VAL_W-1:0]   in_value_in = '0;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic [POS_W-1:0]          out_count_out;
  logic signed [VAL_W-1:0]   out_first_value;
  logic [POS_W-1:0]          out_first_position;
  logic signed [VAL_W-1:0]   out_second_value;
  logic [POS_W-1:0]          out_second_position;

  // Local copy of the list and the results still to come.
  logic signed [VAL_W-1:0]   list_model[$];
  list_result_t              pending_results[$];
  int                        fail_cnt = 0;
  int                        quiet_cycles = 0;
  int                        idle_pct = 0;

  positional_list_with_min_max #(.DEPTH(DEPTH)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_position         (in_position),
    .in_value_in         (in_value_in),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_count_out       (out_count_out),
    .out_first_value     (out_first_value),
    .out_first_position  (out_first_position),
    .out_second_value    (out_second_value),
    .out_second_position (out_second_position)
  );

  always #10 clk = ~clk;

  // Apply one operation to the local list and return the result it causes.
  function automatic list_result_t predict_list_op(plmm_pkg::func_t f, logic [POS_W-1:0] p,
                                                   logic signed [VAL_W-1:0] v);
    list_result_t r;
    int cnt;
    int imax;
    int imin;
    r = '0;
    r.status = plmm_pkg::ST_OK;
    cnt = list_model.size();
    if (f == plmm_pkg::FN_INSERT) begin
      if (cnt >= DEPTH) begin
        r.status = plmm_pkg::ST_FULL;
      end else if (p < 1 || p > cnt + 1) begin
        r.status = plmm_pkg::ST_RANGE;
      end else begin
        list_model.insert(p - 1, v);
      end
    end else if (cnt == 0) begin
      r.status = plmm_pkg::ST_EMPTY;
    end else if (f == plmm_pkg::FN_QUERY) begin
      // The first occurrence wins for both extremes.
      imax = 0;
      imin = 0;
      for (int i = 1; i < cnt; i++) begin
        if (list_model[i] > list_model[imax]) imax = i;
        if (list_model[i] < list_model[imin]) imin = i;
      end
      r.max_val = list_model[imax];
      r.max_pos = POS_W'(imax + 1);
      r.min_val = list_model[imin];
      r.min_pos = POS_W'(imin + 1);
    end else if (p < 1 || p > cnt) begin
      r.status = plmm_pkg::ST_RANGE;
    end else if (f == plmm_pkg::FN_DELETE) begin
      list_model.delete(p - 1);
    end else begin
      r.max_val = list_model[p - 1];
    end
    r.cnt_out = POS_W'(list_model.size());
    return r;
  endfunction

  // Drive one word at the falling edge, with random idle cycles ahead of it,
  // and record its prediction at the accepting edge.
  task automatic send_word(plmm_pkg::func_t f, logic [POS_W-1:0] p,
                           logic signed [VAL_W-1:0] v);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    in_func     <= f;
    in_position <= p;
    in_value_in <= v;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_list_op(f, p, v));
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_results_done();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Values lean toward the extremes and a narrow band that forces ties.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int k;
    k = $urandom_range(0, 8);
    case ($urandom_range(0, 5))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3:    return k - 4;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range positions; the rest cover the whole field.
  function automatic logic [POS_W-1:0] pick_position(int hi);
    if (hi >= 1 && $urandom_range(99) < 85) return POS_W'($urandom_range(1, hi));
    return POS_W'($urandom_range(0, 255));
  endfunction

  // Empty list, range errors, both ends of the list and ties in a query.
  task automatic test_directed();
    send_word(plmm_pkg::FN_QUERY,  8'd0,   0);
    send_word(plmm_pkg::FN_READ,   8'd1,   0);
    send_word(plmm_pkg::FN_DELETE, 8'd1,   0);
    send_word(plmm_pkg::FN_INSERT, 8'd0,   5);
    send_word(plmm_pkg::FN_INSERT, 8'd2,   5);
    send_word(plmm_pkg::FN_INSERT, 8'd255, 5);
    send_word(plmm_pkg::FN_INSERT, 8'd1,   32'sh7FFFFFFF);
    send_word(plmm_pkg::FN_INSERT, 8'd1,   32'sh80000000);
    send_word(plmm_pkg::FN_INSERT, 8'd3,   0);
    send_word(plmm_pkg::FN_INSERT, 8'd2,   -1);
    send_word(plmm_pkg::FN_READ,   8'd0,   0);
    send_word(plmm_pkg::FN_READ,   8'd5,   0);
    send_word(plmm_pkg::FN_READ,   8'd1,   0);
    send_word(plmm_pkg::FN_READ,   8'd4,   0);
    send_word(plmm_pkg::FN_INSERT, 8'd5,   32'sh7FFFFFFF);
    send_word(plmm_pkg::FN_INSERT, 8'd6,   32'sh80000000);
    send_word(plmm_pkg::FN_QUERY,  8'd77,  -9);
    send_word(plmm_pkg::FN_DELETE, 8'd0,   0);
    send_word(plmm_pkg::FN_DELETE, 8'd7,   0);
    send_word(plmm_pkg::FN_DELETE, 8'd200, 0);
    send_word(plmm_pkg::FN_DELETE, 8'd6,   0);
    send_word(plmm_pkg::FN_DELETE, 8'd1,   0);
    send_word(plmm_pkg::FN_QUERY,  8'd0,   0);
  endtask

  // Fill the list to the top, hit the full case, then empty it again.
  task automatic test_full_list();
    int n;
    idle_pct = 15;
    while (list_model.size() < DEPTH)
      send_word(plmm_pkg::FN_INSERT, POS_W'($urandom_range(1, list_model.size() + 1)),
                pick_value());
    send_word(plmm_pkg::FN_INSERT, POS_W'(DEPTH + 1), 1);
    send_word(plmm_pkg::FN_INSERT, 8'd0, 1);
    send_word(plmm_pkg::FN_QUERY,  8'd0, 0);
    send_word(plmm_pkg::FN_READ,   POS_W'(DEPTH), 0);
    send_word(plmm_pkg::FN_READ,   POS_W'(DEPTH + 1), 0);
    send_word(plmm_pkg::FN_DELETE, POS_W'(DEPTH), 0);
    send_word(plmm_pkg::FN_INSERT, POS_W'(DEPTH), 32'sh55555555);
    n = 0;
    while (list_model.size() > 0) begin
      send_word(plmm_pkg::FN_DELETE, POS_W'($urandom_range(1, list_model.size())), 0);
      n++;
      if (n % 16 == 0) send_word(plmm_pkg::FN_QUERY, 8'd0, 0);
    end
    send_word(plmm_pkg::FN_QUERY, 8'd0, 0);
  endtask

  // Random mix of all four operations, with one full pause halfway.
  task automatic test_random_mix(int pct, int n);
    int cnt;
    int r;
    int ins_pct;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_results_done();
      cnt = list_model.size();
      ins_pct = (cnt < DEPTH / 2) ? 55 : 35;
      r = $urandom_range(99);
      if (r < ins_pct)
        send_word(plmm_pkg::FN_INSERT, pick_position(cnt + 1), pick_value());
      else if (r < ins_pct + 25)
        send_word(plmm_pkg::FN_DELETE, pick_position(cnt), $urandom);
      else if (r < ins_pct + 33)
        send_word(plmm_pkg::FN_QUERY, POS_W'($urandom_range(0, 255)), $urandom);
      else
        send_word(plmm_pkg::FN_READ, pick_position(cnt), $urandom);
    end
  endtask

  // Compare each strobed result with the oldest prediction; watch for stalls.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        got.status  = plmm_pkg::status_t'(out_status);
        got.cnt_out = out_count_out;
        got.max_val = out_first_value;
        got.max_pos = out_first_position;
        got.min_val = out_second_value;
        got.min_pos = out_second_position;
        if (pending_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("%0t: result word with none expected", $realtime);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.cnt_out !== want.cnt_out ||
              got.max_val !== want.max_val || got.max_pos !== want.max_pos ||
              got.min_val !== want.min_val || got.min_pos !== want.min_pos) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch exp st=%0d cnt=%0d v1=%0d p1=%0d v2=%0d p2=%0d,",
                       $realtime, want.status, want.cnt_out, want.max_val, want.max_pos,
                       want.min_val, want.min_pos,
                       " got st=%0d cnt=%0d v1=%0d p1=%0d v2=%0d p2=%0d",
                       got.status, got.cnt_out, got.max_val,
                       got.max_pos, got.min_val, got.min_pos);
          end
        end
      end
      // A query or read holds the port for a whole sweep of the row; far beyond
      // that with nothing moving means the block has hung.
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WD_LIMIT) begin
        $display("%0t: watchdog expired", $realtime);
        $display("** positional_list_with_min_max: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_list();
    test_random_mix(0, 360);
    test_random_mix(64, 360);
    test_random_mix(15, 360);
    wait_results_done();
    repeat (DEPTH + 4) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("** positional_list_with_min_max: PASSED **");
    end else begin
      $display("** positional_list_with_min_max: FAILED **");
    end
    $finish;
  end

endmodule

@@ positional_list_with_min_max.f @@
hw/rtl/plmm_pkg.sv
hw/rtl/plmm_cell.sv
hw/rtl/plmm_chain.sv
hw/rtl/positional_list_with_min_max.sv
hw/rtl/plmm_checker.sv
tb/tb.sv
